>>> hw/rtl/vector3_normalize_macros.svh
// assertion macros for the vector normalizer checker
`ifndef VECTOR3_NORMALIZE_MACROS_SVH
`define VECTOR3_NORMALIZE_MACROS_SVH

// same-cycle implication, quiet during reset
`define VN_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, quiet during reset
`define VN_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// implication checked also while reset is high
`define VN_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/vn_pkg.sv
// ---------------------------------------------------------------------------
// vn_pkg
// shared widths, constants and types of the 3d vector normalizer
// ---------------------------------------------------------------------------
package vn_pkg;

  localparam int VN_FRAC_BITS = 16;
  localparam int IN_W         = 32;
  localparam int EPS_W        = 31;
  localparam int SUM_W        = 2 * IN_W;
  localparam int ROOT_W       = SUM_W / 2;
  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

  // control that travels beside each request
  typedef struct packed {
    logic valid;
    logic zero;
  } ctrl_t;

endpackage

>>> hw/rtl/vector3_normalize.sv
// ---------------------------------------------------------------------------
// vector3_normalize
// normalizes a signed q15.16 3d vector to a signed q1.16 unit vector
// ---------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_stall   in_x, in_y, in_z
//  out      out_valid / out_stall unit_x, unit_y, unit_z
//  cfg      cfg_valid / cfg_ready cfg_data (eps_threshold)
//
//  one vector per cycle while no result waits under out_stall; each vector
//  passes the 32-stage square root and the FRAC_BITS+1 stage dividers
//  rst is synchronous and empties the pipe; eps_threshold resets to 1
//  the whole pipe holds while a result waits under out_stall
// ---------------------------------------------------------------------------
module vector3_normalize import vn_pkg::*; #(
  parameter int FRAC_BITS = VN_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [IN_W-1:0] in_x,
  input  logic signed [IN_W-1:0] in_y,
  input  logic signed [IN_W-1:0] in_z,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [FRAC_BITS+1:0] unit_x,
  output logic signed [FRAC_BITS+1:0] unit_y,
  output logic signed [FRAC_BITS+1:0] unit_z,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [EPS_W-1:0]      cfg_data
);

  localparam int OUT_W  = FRAC_BITS + 2;
  localparam int SIDE_W = 3 * IN_W + 3;
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  logic             en;
  logic [EPS_W-1:0] eps_threshold;

  // pipe advances unless the output holds an untaken result
  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      eps_threshold <= EPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      eps_threshold <= cfg_data;
    end
  end

  // stage 1: magnitudes, signs and the zero-result test
  logic [IN_W-1:0] ax_next, ay_next, az_next;
  logic            all_small;
  ctrl_t           s1_ctrl;
  logic [IN_W-1:0] s1_ax, s1_ay, s1_az;
  logic [2:0]      s1_neg;

  always_comb begin
    ax_next   = in_x[IN_W-1] ? (IN_W)'(-in_x) : in_x;
    ay_next   = in_y[IN_W-1] ? (IN_W)'(-in_y) : in_y;
    az_next   = in_z[IN_W-1] ? (IN_W)'(-in_z) : in_z;
    all_small = (ax_next < {1'b0, eps_threshold}) && (ay_next < {1'b0, eps_threshold}) &&
                (az_next < {1'b0, eps_threshold});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctrl <= '0;
    end else if (en) begin
      s1_ctrl.valid <= in_valid;
      s1_ctrl.zero  <= all_small || ((ax_next | ay_next | az_next) == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ax  <= ax_next;
      s1_ay  <= ay_next;
      s1_az  <= az_next;
      s1_neg <= {in_z[IN_W-1], in_y[IN_W-1], in_x[IN_W-1]};
    end
  end

  // stage 2: squares
  ctrl_t             s2_ctrl;
  logic [SUM_W-1:0]  s2_sqx, s2_sqy, s2_sqz;
  logic [IN_W-1:0]   s2_ax, s2_ay, s2_az;
  logic [2:0]        s2_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctrl <= '0;
    end else if (en) begin
      s2_ctrl <= s1_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sqx <= SUM_W'(s1_ax) * SUM_W'(s1_ax);
      s2_sqy <= SUM_W'(s1_ay) * SUM_W'(s1_ay);
      s2_sqz <= SUM_W'(s1_az) * SUM_W'(s1_az);
      s2_ax  <= s1_ax;
      s2_ay  <= s1_ay;
      s2_az  <= s1_az;
      s2_neg <= s1_neg;
    end
  end

  // stage 3: sum of squares, fits in 64 bits
  ctrl_t             s3_ctrl;
  logic [SUM_W-1:0]  s3_sum;
  logic [SIDE_W-1:0] s3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_ctrl <= '0;
    end else if (en) begin
      s3_ctrl <= s2_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sum  <= s2_sqx + s2_sqy + s2_sqz;
      s3_side <= {s2_neg, s2_az, s2_ay, s2_ax};
    end
  end

  // magnitude
  ctrl_t             sq_ctrl;
  logic [ROOT_W-1:0] sq_root;
  logic [SIDE_W-1:0] sq_side;

  vn_isqrt #(
    .SIDE_W (SIDE_W)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .ctrl_in  (s3_ctrl),
    .radicand (s3_sum),
    .side_in  (s3_side),
    .ctrl_out (sq_ctrl),
    .root     (sq_root),
    .side_out (sq_side)
  );

  // one divider lane per component
  ctrl_t              dv_ctrl [3];
  logic [FRAC_BITS:0] dv_quot [3];
  logic               dv_neg  [3];

  for (genvar k = 0; k < 3; k++) begin : g_lane
    vn_divider #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctrl_in  (sq_ctrl),
      .dividend (sq_side[k*IN_W +: IN_W]),
      .mag      (sq_root),
      .neg_in   (sq_side[3*IN_W + k]),
      .ctrl_out (dv_ctrl[k]),
      .quot     (dv_quot[k]),
      .neg_out  (dv_neg[k])
    );
  end

  // output stage: clamp, sign and zero-vector select
  logic [OUT_W-1:0] comp_next [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [FRAC_BITS:0] q;
      q = (dv_quot[k] > ONE) ? ONE : dv_quot[k];
      if (dv_ctrl[0].zero) begin
        comp_next[k] = '0;
      end else if (dv_neg[k]) begin
        comp_next[k] = OUT_W'(-{1'b0, q});
      end else begin
        comp_next[k] = {1'b0, q};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_ctrl[0].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit_x <= comp_next[0];
      unit_y <= comp_next[1];
      unit_z <= comp_next[2];
    end
  end

endmodule

>>> hw/rtl/vn_isqrt.sv
// ---------------------------------------------------------------------------
// vn_isqrt
// pipelined floor square root, one result bit per stage, with side data
// ---------------------------------------------------------------------------
module vn_isqrt import vn_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  ctrl_t               ctrl_in,
  input  logic [SUM_W-1:0]    radicand,
  input  logic [SIDE_W-1:0]   side_in,
  output ctrl_t               ctrl_out,
  output logic [ROOT_W-1:0]   root,
  output logic [SIDE_W-1:0]   side_out
);

  localparam int REM_W = ROOT_W + 2;

  ctrl_t              ctrl_q [ROOT_W];
  logic [REM_W-1:0]   rem_q  [ROOT_W];
  logic [ROOT_W-1:0]  root_q [ROOT_W];
  logic [SUM_W-1:0]   rad_q  [ROOT_W];
  logic [SIDE_W-1:0]  side_q [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_step
    ctrl_t             c_prev;
    logic [REM_W-1:0]  r_prev;
    logic [ROOT_W-1:0] q_prev;
    logic [SUM_W-1:0]  v_prev;
    logic [SIDE_W-1:0] d_prev;
    logic [REM_W:0]    r_shift;
    logic [REM_W:0]    trial;
    logic [REM_W:0]    diff;
    logic              ge;

    if (s == 0) begin : g_first
      assign c_prev = ctrl_in;
      assign r_prev = '0;
      assign q_prev = '0;
      assign v_prev = radicand;
      assign d_prev = side_in;
    end else begin : g_rest
      assign c_prev = ctrl_q[s-1];
      assign r_prev = rem_q[s-1];
      assign q_prev = root_q[s-1];
      assign v_prev = rad_q[s-1];
      assign d_prev = side_q[s-1];
    end

    // bring down two radicand bits and try root*4+1
    always_comb begin
      r_shift = {r_prev[REM_W-2:0], v_prev[SUM_W-1 -: 2]};
      trial   = {1'b0, q_prev, 2'b01};
      ge      = (r_shift >= trial);
      diff    = r_shift - trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctrl_q[s] <= '0;
      end else if (en) begin
        ctrl_q[s] <= c_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s]  <= ge ? diff[REM_W-1:0] : r_shift[REM_W-1:0];
        root_q[s] <= {q_prev[ROOT_W-2:0], ge};
        rad_q[s]  <= {v_prev[SUM_W-3:0], 2'b00};
        side_q[s] <= d_prev;
      end
    end
  end

  assign ctrl_out = ctrl_q[ROOT_W-1];
  assign root     = root_q[ROOT_W-1];
  assign side_out = side_q[ROOT_W-1];

endmodule

>>> hw/rtl/vn_divider.sv
// ---------------------------------------------------------------------------
// vn_divider
// pipelined restoring divider, a * 2^frac / mag for a <= mag, one bit a stage
// ---------------------------------------------------------------------------
module vn_divider import vn_pkg::*; #(
  parameter int FRAC_BITS = VN_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  ctrl_t                ctrl_in,
  input  logic [IN_W-1:0]      dividend,
  input  logic [ROOT_W-1:0]    mag,
  input  logic                 neg_in,
  output ctrl_t                ctrl_out,
  output logic [FRAC_BITS:0]   quot,
  output logic                 neg_out
);

  localparam int STEPS = FRAC_BITS + 1;

  ctrl_t               ctrl_q [STEPS];
  logic [ROOT_W-1:0]   rem_q  [STEPS];
  logic [FRAC_BITS:0]  quot_q [STEPS];
  logic [ROOT_W-1:0]   mag_q  [STEPS];
  logic                neg_q  [STEPS];

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    ctrl_t              c_prev;
    logic [ROOT_W:0]    t;
    logic [FRAC_BITS:0] q_prev;
    logic [ROOT_W-1:0]  m_prev;
    logic               n_prev;
    logic [ROOT_W:0]    diff;
    logic               ge;

    if (s == 0) begin : g_first
      assign c_prev = ctrl_in;
      assign t      = {1'b0, dividend};
      assign q_prev = '0;
      assign m_prev = mag;
      assign n_prev = neg_in;
    end else begin : g_rest
      assign c_prev = ctrl_q[s-1];
      assign t      = {rem_q[s-1], 1'b0};
      assign q_prev = quot_q[s-1];
      assign m_prev = mag_q[s-1];
      assign n_prev = neg_q[s-1];
    end

    // compare partial remainder against the magnitude
    always_comb begin
      ge   = (t >= {1'b0, m_prev});
      diff = t - {1'b0, m_prev};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctrl_q[s] <= '0;
      end else if (en) begin
        ctrl_q[s] <= c_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s]  <= ge ? diff[ROOT_W-1:0] : t[ROOT_W-1:0];
        quot_q[s] <= {q_prev[FRAC_BITS-1:0], ge};
        mag_q[s]  <= m_prev;
        neg_q[s]  <= n_prev;
      end
    end
  end

  assign ctrl_out = ctrl_q[STEPS-1];
  assign quot     = quot_q[STEPS-1];
  assign neg_out  = neg_q[STEPS-1];

endmodule

>>> hw/rtl/vn_checker.sv
// ---------------------------------------------------------------------------
// vn_checker
// port-level checks of the vector normalizer, bound to the top level
// ---------------------------------------------------------------------------
`include "vector3_normalize_macros.svh"

module vn_checker import vn_pkg::*; #(
  parameter int FRAC_BITS = VN_FRAC_BITS
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [FRAC_BITS+1:0]  unit_x,
  input logic [FRAC_BITS+1:0]  unit_y,
  input logic [FRAC_BITS+1:0]  unit_z
);

  localparam int ONE = 1 << FRAC_BITS;

  // a waiting result holds its value
  `VN_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(unit_x) && $stable(unit_y) && $stable(unit_z))

  // input only backs up while a result is blocked
  `VN_ASSERT_IMPLY(a_stall_cause, clk, rst, in_stall, out_valid && out_stall)

  // components stay within one unit
  `VN_ASSERT_IMPLY(a_range, clk, rst, out_valid, $signed(unit_x) <= ONE && $signed(unit_x) >= -ONE && $signed(unit_y) <= ONE && $signed(unit_y) >= -ONE && $signed(unit_z) <= ONE && $signed(unit_z) >= -ONE)

  // reset empties the output
  `VN_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst), !out_valid)

endmodule

bind vector3_normalize vn_checker #(.FRAC_BITS(FRAC_BITS)) u_vn_checker (.*);

>>> verif/tb_vector3_normalize.sv
// ---------------------------------------------------------------------------
// tb_vector3_normalize
// self-checking bench: random and directed vectors against a bit-true model
// of the normalizer, with random gaps and stalls and eps_threshold phases
// ---------------------------------------------------------------------------
module tb_vector3_normalize;
  import vn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB    = VN_FRAC_BITS;
  localparam int OW    = FB + 2;
  localparam int LAT   = 3 + 32 + (FB + 1) + 1;
  localparam int WDOG  = 20000;

  typedef struct {
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    logic signed [IN_W-1:0] z;
  } vec_req_t;

  typedef struct {
    logic signed [OW-1:0] x;
    logic signed [OW-1:0] y;
    logic signed [OW-1:0] z;
  } unit_vec_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic signed [IN_W-1:0] in_x, in_y, in_z;
  logic out_valid;
  logic out_stall;
  logic signed [OW-1:0] unit_x, unit_y, unit_z;
  logic cfg_valid;
  logic cfg_ready;
  logic [EPS_W-1:0] cfg_data;

  vector3_normalize dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_x(in_x), .in_y(in_y), .in_z(in_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  vec_req_t  pending_vecs[$];
  unit_vec_t expected_units[$];
  logic [EPS_W-1:0] eps_model;
  int  errors;
  int  idle_cycles;
  int  gap_left;
  int  stall_left;
  bit  feed_on;
  bit  drain_on;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // random gap length, mostly short with some long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // floor square root, digit by digit
  function automatic logic [ROOT_W-1:0] root_floor(logic [SUM_W-1:0] v);
    logic [SUM_W-1:0] rem;
    logic [SUM_W-1:0] res;
    logic [SUM_W-1:0] bitv;
    rem  = v;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[ROOT_W-1:0];
  endfunction

  function automatic logic signed [OW-1:0] scale_component(logic [IN_W:0] a, bit neg,
                                                          logic [ROOT_W-1:0] mag);
    logic [SUM_W-1:0] q;
    logic [SUM_W-1:0] one;
    logic [OW-1:0] r;
    one = 64'd1 << FB;
    q   = ({31'd0, a} << FB) / SUM_W'(mag);
    if (q > one) q = one;
    r = q[OW-1:0];
    return neg ? -r : r;
  endfunction

  // expected unit vector for one request
  function automatic unit_vec_t normalize_vec(vec_req_t v);
    unit_vec_t u;
    logic [IN_W:0] ax, ay, az;
    logic [SUM_W-1:0] sum;
    logic [ROOT_W-1:0] mag;
    u  = '{x: '0, y: '0, z: '0};
    ax = v.x[IN_W-1] ? -{1'b1, v.x} : {1'b0, v.x};
    ay = v.y[IN_W-1] ? -{1'b1, v.y} : {1'b0, v.y};
    az = v.z[IN_W-1] ? -{1'b1, v.z} : {1'b0, v.z};
    if (ax < eps_model && ay < eps_model && az < eps_model) return u;
    sum = ax * ax + ay * ay + az * az;
    mag = root_floor(sum);
    if (mag == 0) return u;
    u.x = scale_component(ax, v.x[IN_W-1], mag);
    u.y = scale_component(ay, v.y[IN_W-1], mag);
    u.z = scale_component(az, v.z[IN_W-1], mag);
    return u;
  endfunction

  task automatic report_mismatch(string what, logic [OW-1:0] got, logic [OW-1:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, $signed(got),
             $signed(want), $time);
    errors++;
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) gap_left <= pick_gap();
      if (feed_on && pending_vecs.size() > 0 && (in_valid ? gap_left == 0 && pick_gap() == 0
                                                       : gap_left == 0)) begin
        vec_req_t v;
        v = pending_vecs.pop_front();
        expected_units.push_back(normalize_vec(v));
        in_valid <= 1'b1;
        in_x <= v.x;
        in_y <= v.y;
        in_z <= v.z;
      end else begin
        in_valid <= 1'b0;
        if (!in_valid && gap_left > 0) gap_left <= gap_left - 1;
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        unit_vec_t w;
        if (expected_units.size() == 0) begin
          $display("unexpected result at %0t", $time);
          errors++;
        end else begin
          w = expected_units.pop_front();
          if (unit_x !== w.x) report_mismatch("unit_x", unit_x, w.x);
          if (unit_y !== w.y) report_mismatch("unit_y", unit_y, w.y);
          if (unit_z !== w.z) report_mismatch("unit_z", unit_z, w.z);
        end
      end
      if (!drain_on) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else begin
        stall_left <= pick_gap();
        out_stall  <= 1'b0;
      end
    end
  end

  // watchdog on accepted traffic
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic logic signed [IN_W-1:0] rand_comp();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      1: return $signed(32'($urandom_range(0, 4))) - 2;
      2, 3: return $signed(32'($urandom_range(0, 20'hFFFFF))) - 32'sh80000;
      4, 5: return $signed(32'($urandom_range(0, 32'h3FFFFFF))) - 32'sh2000000;
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic write_eps(logic [EPS_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    eps_model = v;
  endtask

  task automatic queue_vec(logic signed [IN_W-1:0] x, logic signed [IN_W-1:0] y,
                           logic signed [IN_W-1:0] z);
    vec_req_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    pending_vecs.push_back(v);
  endtask

  // run phases: drain, then settle the pipe before the next register write
  task automatic run_phase();
    int guard;
    guard = 0;
    feed_on = 1'b1;
    while ((pending_vecs.size() > 0 || expected_units.size() > 0 || in_valid) &&
           guard < 1000000) begin
      @(posedge clk);
      guard++;
    end
    feed_on = 1'b0;
    repeat (LAT + 5) @(posedge clk);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) queue_vec(rand_comp(), rand_comp(), rand_comp());
  endtask

  // stimulus
  initial begin
    logic [EPS_W-1:0] eps_set[5];
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_x      = '0;
    in_y      = '0;
    in_z      = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    errors    = 0;
    feed_on   = 1'b0;
    drain_on  = 1'b1;
    eps_model = EPS_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, signs, near-zero and unit axis cases at reset eps
    queue_vec(0, 0, 0);
    queue_vec(32'sh80000000, 0, 0);
    queue_vec(32'sh7FFFFFFF, 0, 0);
    queue_vec(32'sh80000000, 32'sh80000000, 32'sh80000000);
    queue_vec(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    queue_vec(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
    queue_vec(32'sh00010000, 0, 0);
    queue_vec(0, -32'sh00010000, 0);
    queue_vec(0, 0, 1);
    queue_vec(-1, -1, -1);
    queue_vec(32'sh00030000, 32'sh00040000, 0);
    queue_vec(-32'sh00030000, 32'sh00040000, -32'sh000C0000);
    queue_vec(32'sh55555555, 32'shAAAAAAAA, 32'sh0F0F0F0F);
    run_phase();

    // eps at zero: the all-zero vector has zero magnitude
    write_eps('0);
    queue_vec(0, 0, 0);
    queue_vec(1, 0, 0);
    queue_vec(0, 0, -1);
    queue_random(150);
    run_phase();

    // largest eps: almost every vector counts as near zero
    write_eps({EPS_W{1'b1}});
    queue_vec(32'sh7FFFFFFE, 0, 0);
    queue_vec(32'sh7FFFFFFF, 0, 0);
    queue_vec(32'sh80000000, 0, 0);
    queue_vec(0, 32'sh80000001, 0);
    queue_random(150);
    run_phase();

    // mid settings around the random magnitudes
    eps_set = '{31'h00010000, 31'h00080000, 31'h02000000, 31'h00000002, 31'h40000000};
    foreach (eps_set[i]) begin
      write_eps(eps_set[i]);
      queue_random(i == 0 ? 250 : 170);
      run_phase();
    end

    // random settings, including a run with no receiver stall
    for (int k = 0; k < 2; k++) begin
      write_eps(31'($urandom()));
      drain_on = (k == 0) ? 1'b0 : 1'b1;
      queue_random(60);
      run_phase();
    end

    if (errors == 0 && expected_units.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
